FILE: src/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared constants, codes and field widths for the bilinear texture sampler.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int MAX_SIDE_DEF       = 256;
  localparam int COMPONENT_BITS_DEF = 16;

  localparam int FRAC_W      = 16;  // fraction bits of u, v and the lerp weights
  localparam int COORD_W     = 24;
  localparam int IDX_W       = 16;
  localparam int COLOR_W     = 16;
  localparam int CFG_SIDE_W  = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 48;

  // input word layout
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_RED_LSB   = 16;
  localparam int IN_GREEN_LSB = 32;
  localparam int IN_BLUE_LSB  = 48;
  localparam int IN_U_LSB     = 64;
  localparam int IN_V_LSB     = 88;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SINGLE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  // sample and write flags that travel with each pipeline stage
  typedef struct packed {
    logic sample;
    logic write;
  } stage_ctl_t;

endpackage

FILE: src/tbs_texel_ram.sv
// ----------------------------------------------------------------------------
// tbs_texel_ram
// One texel bank: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbs_texel_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tbs_coord.sv
// ----------------------------------------------------------------------------
// tbs_coord
// Wraps u and v into the texture, forms the four neighbor addresses and
// carries texel writes to the memory stage in order with the samples.
// ----------------------------------------------------------------------------
module tbs_coord
  import tbs_pkg::*;
#(
  parameter int MAX_SIDE       = MAX_SIDE_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE,
  localparam int AW     = $clog2(DEPTH),
  localparam int DW     = 3 * COMPONENT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  stage_ctl_t         in_ctl,
  input  logic [IDX_W-1:0]   idx,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  input  logic [FRAC_W-1:0]  u_frac,
  input  logic [FRAC_W-1:0]  v_frac,
  input  logic [SIDE_W-1:0]  width_side,
  input  logic [SIDE_W-1:0]  height_side,
  output logic [AW-1:0]      addr00,
  output logic [AW-1:0]      addr01,
  output logic [AW-1:0]      addr10,
  output logic [AW-1:0]      addr11,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [DW-1:0]      wr_data,
  output logic [FRAC_W-1:0]  tx,
  output logic [FRAC_W-1:0]  ty
);

  localparam int PW = FRAC_W + SIDE_W;
  localparam int YW = 2 * SIDE_W;

  // stage 1
  logic          wr1;
  logic [PW-1:0] px1, py1;
  logic [AW-1:0] widx1;
  logic [DW-1:0] wdata1;
  // stage 2
  logic              wr2;
  logic [SIDE_W-1:0] x0_2, x1_2;
  logic [YW-1:0]     wy0_2, wy1_2;
  logic [FRAC_W-1:0] tx2, ty2;
  logic [AW-1:0]     widx2;
  logic [DW-1:0]     wdata2;
  // stage 3
  logic wr3;

  logic [SIDE_W-1:0] x0, y0, x1, y1;
  logic [SIDE_W:0]   x_inc, y_inc;

  // the integer part of u only adds whole turns, so only the fraction matters
  always_comb begin
    x0    = px1[FRAC_W +: SIDE_W];
    y0    = py1[FRAC_W +: SIDE_W];
    x_inc = {1'b0, x0} + (SIDE_W+1)'(1);
    y_inc = {1'b0, y0} + (SIDE_W+1)'(1);
    x1    = (x_inc >= {1'b0, width_side})  ? '0 : x_inc[SIDE_W-1:0];
    y1    = (y_inc >= {1'b0, height_side}) ? '0 : y_inc[SIDE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr1 <= 1'b0;
      wr2 <= 1'b0;
      wr3 <= 1'b0;
    end else if (adv) begin
      wr1 <= in_ctl.write && (32'(idx) < DEPTH);
      wr2 <= wr1;
      wr3 <= wr2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px1    <= PW'(u_frac) * PW'(width_side);
      py1    <= PW'(v_frac) * PW'(height_side);
      widx1  <= AW'(idx);
      wdata1 <= {COMPONENT_BITS'(blue), COMPONENT_BITS'(green), COMPONENT_BITS'(red)};

      x0_2   <= x0;
      x1_2   <= x1;
      tx2    <= px1[FRAC_W-1:0];
      ty2    <= py1[FRAC_W-1:0];
      wy0_2  <= YW'(width_side) * YW'(y0);
      wy1_2  <= YW'(width_side) * YW'(y1);
      widx2  <= widx1;
      wdata2 <= wdata1;

      addr00  <= AW'(YW'(x0_2) + wy0_2);
      addr01  <= AW'(YW'(x0_2) + wy1_2);
      addr10  <= AW'(YW'(x1_2) + wy0_2);
      addr11  <= AW'(YW'(x1_2) + wy1_2);
      tx      <= tx2;
      ty      <= ty2;
      wr_addr <= widx2;
      wr_data <= wdata2;
    end
  end

  assign wr_en = wr3 && adv;

endmodule

FILE: src/tbs_filter.sv
// ----------------------------------------------------------------------------
// tbs_filter
// Two lerps along v, then one along u, per component; clamps to the
// output width and broadcasts red in single-channel mode.
// ----------------------------------------------------------------------------
module tbs_filter
  import tbs_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  localparam int DW = 3 * COMPONENT_BITS
) (
  input  logic               clk,
  input  logic               adv,
  input  logic               single_channel,
  input  logic [FRAC_W-1:0]  tx_in,
  input  logic [FRAC_W-1:0]  ty_in,
  input  logic [DW-1:0]      q00,
  input  logic [DW-1:0]      q01,
  input  logic [DW-1:0]      q10,
  input  logic [DW-1:0]      q11,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue
);

  localparam int CB = COMPONENT_BITS;
  localparam int AccW = CB + FRAC_W + 2;
  localparam logic signed [AccW-1:0] HALF = AccW'(1 << (FRAC_W - 1));

  // a*(1-t) + b*t rounded, written as a + (b-a)*t
  function automatic logic [CB-1:0] lerp(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                         input logic [FRAC_W-1:0] t);
    logic signed [CB:0]     d;
    logic signed [AccW-1:0] acc;
    d   = signed'({1'b0, b}) - signed'({1'b0, a});
    acc = signed'({2'b00, a, {FRAC_W{1'b0}}}) + d * signed'({1'b0, t}) + HALF;
    return acc[FRAC_W +: CB];
  endfunction

  function automatic logic [COLOR_W-1:0] clamp(input logic [CB-1:0] v);
    if ((v >> COLOR_W) != '0) begin
      return '1;
    end
    return COLOR_W'(v);
  endfunction

  logic [FRAC_W-1:0] tx4, ty4, tx5;
  logic [CB-1:0]     c0 [3];
  logic [CB-1:0]     c1 [3];
  logic [CB-1:0]     res [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      tx4 <= tx_in;
      ty4 <= ty_in;
      tx5 <= tx4;
      for (int k = 0; k < 3; k++) begin
        c0[k] <= lerp(q00[k*CB +: CB], q01[k*CB +: CB], ty4);
        c1[k] <= lerp(q10[k*CB +: CB], q11[k*CB +: CB], ty4);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[k] = lerp(c0[k], c1[k], tx5);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red   <= clamp(res[0]);
      out_green <= single_channel ? clamp(res[0]) : clamp(res[1]);
      out_blue  <= single_channel ? clamp(res[0]) : clamp(res[2]);
    end
  end

endmodule

FILE: src/bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// A sample word passes the coordinate, texel bank and filter registers to
// m_tdata. Throughput: one word per cycle unless a held result stalls the
// pipeline, writes and samples mixed; the four texel reads come from four
// replicated texel banks, each written by every write. Reset clears config
// to 256 x 256 rgb and empties the pipeline; texel memory is not cleared.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler
  import tbs_pkg::*;
#(
  parameter int MAX_SIDE       = MAX_SIDE_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // texel_index, texel_red, texel_green, texel_blue, u_coord, v_coord
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_red, out_green, out_blue
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = 3 * COMPONENT_BITS;

  logic [CFG_SIDE_W-1:0] cfg_width, cfg_height;
  logic                  cfg_single;
  logic [SIDE_W-1:0]     width_side, height_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_SIDE_W'(256);
      cfg_height <= CFG_SIDE_W'(256);
      cfg_single <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  cfg_width  <= cfg_data;
        REG_HEIGHT: cfg_height <= cfg_data;
        REG_SINGLE: cfg_single <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width == '0) begin
      width_side = SIDE_W'(1);
    end else if (int'(cfg_width) > MAX_SIDE) begin
      width_side = SIDE_W'(MAX_SIDE);
    end else begin
      width_side = SIDE_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      height_side = SIDE_W'(1);
    end else if (int'(cfg_height) > MAX_SIDE) begin
      height_side = SIDE_W'(MAX_SIDE);
    end else begin
      height_side = SIDE_W'(cfg_height);
    end
  end

  // whole pipeline moves together; the output register parts the two sides
  logic       adv;
  stage_ctl_t in_ctl;
  logic [4:0] smp;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign in_ctl.sample = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_SAMPLE);
  assign in_ctl.write  = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      smp      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      smp      <= {smp[3:0], in_ctl.sample};
      m_tvalid <= smp[4];
    end
  end

  logic [AW-1:0]     addr [4];
  logic [DW-1:0]     q    [4];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DW-1:0]     wr_data;
  logic [FRAC_W-1:0] tx, ty;

  tbs_coord #(
    .MAX_SIDE       (MAX_SIDE),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_coord (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_ctl      (in_ctl),
    .idx         (s_tdata[IN_IDX_LSB +: IDX_W]),
    .red         (s_tdata[IN_RED_LSB +: COLOR_W]),
    .green       (s_tdata[IN_GREEN_LSB +: COLOR_W]),
    .blue        (s_tdata[IN_BLUE_LSB +: COLOR_W]),
    .u_frac      (s_tdata[IN_U_LSB +: FRAC_W]),
    .v_frac      (s_tdata[IN_V_LSB +: FRAC_W]),
    .width_side  (width_side),
    .height_side (height_side),
    .addr00      (addr[0]),
    .addr01      (addr[1]),
    .addr10      (addr[2]),
    .addr11      (addr[3]),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .tx          (tx),
    .ty          (ty)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    tbs_texel_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (adv),
      .raddr (addr[b]),
      .rdata (q[b])
    );
  end

  tbs_filter #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_filter (
    .clk            (clk),
    .adv            (adv),
    .single_channel (cfg_single),
    .tx_in          (tx),
    .ty_in          (ty),
    .q00            (q[0]),
    .q01            (q[1]),
    .q10            (q[2]),
    .q11            (q[3]),
    .out_red        (m_tdata[0 +: COLOR_W]),
    .out_green      (m_tdata[COLOR_W +: COLOR_W]),
    .out_blue       (m_tdata[2*COLOR_W +: COLOR_W])
  );

endmodule

FILE: src/tbs_checker.sv
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks on the texture sampler, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker
  import tbs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word after reset");

  // input side stalls only while a result is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input stalled without a held result");

  a_sample_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) ##1 m_tready ##1 m_tready ##1 m_tready
      ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("sample result missing");

endmodule

bind bilinear_texture_sampler tbs_checker u_tbs_checker (.*);

FILE: dv/bilinear_texture_sampler_tb.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_tb
// Writes texels into the sampler and samples them with wrapped coordinates,
// checking every filtered rgb word against a local bilinear predictor over
// several texture sizes and both channel modes, with random stalls.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_tb;
  import tbs_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bilinear_texture_sampler uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  rgb_t       texels [65536];
  int         tex_w, tex_h;
  bit         grey_mode;
  rgb_t       expected_rgb [$];
  int         errors, samples_checked, items_sent, cycles;
  bit         rx_enable;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout at %0t", $time);
      $display("[bilinear_texture_sampler] ERROR");
      $finish;
    end
  end

  // output stall pattern
  int stall_left;
  always @(posedge clk) begin
    if (rst || !rx_enable) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = expected_rgb.pop_front();
        samples_checked++;
        if (got.red !== want.red) begin
          errors++;
          $display("%0t: red exp %h got %h", $time, want.red, got.red);
        end
        if (got.green !== want.green) begin
          errors++;
          $display("%0t: green exp %h got %h", $time, want.green, got.green);
        end
        if (got.blue !== want.blue) begin
          errors++;
          $display("%0t: blue exp %h got %h", $time, want.blue, got.blue);
        end
      end
    end
  end

  function automatic void wrap_coord(input logic signed [COORD_W-1:0] c, input int side,
                                     output int i0, output int i1, output int frac);
    longint m, p;
    m = longint'(side) * 65536;
    p = (longint'(c) * side) % m;
    if (p < 0) p += m;
    i0 = int'(p / 65536);
    frac = int'(p % 65536);
    i1 = (i0 + 1 >= side) ? 0 : i0 + 1;
  endfunction

  function automatic longint blend(longint a, longint b, int t);
    return (a * (65536 - t) + b * t + 32768) >>> 16;
  endfunction

  function automatic logic [COLOR_W-1:0] filter_channel(longint c00, longint c01, longint c10,
                                                        longint c11, int tx, int ty);
    longint r;
    r = blend(blend(c00, c01, ty), blend(c10, c11, ty), tx);
    return (r > 65535) ? 16'hffff : r[15:0];
  endfunction

  function automatic rgb_t predict_sample(logic signed [COORD_W-1:0] u,
                                          logic signed [COORD_W-1:0] v);
    int x0, x1, y0, y1, tx, ty;
    rgb_t t00, t01, t10, t11, res;
    wrap_coord(u, tex_w, x0, x1, tx);
    wrap_coord(v, tex_h, y0, y1, ty);
    t00 = texels[x0 + tex_w * y0];
    t01 = texels[x0 + tex_w * y1];
    t10 = texels[x1 + tex_w * y0];
    t11 = texels[x1 + tex_w * y1];
    res.red = filter_channel(t00.red, t01.red, t10.red, t11.red, tx, ty);
    if (grey_mode) begin
      res.green = res.red;
      res.blue = res.red;
    end else begin
      res.green = filter_channel(t00.green, t01.green, t10.green, t11.green, tx, ty);
      res.blue = filter_channel(t00.blue, t01.blue, t10.blue, t11.blue, tx, ty);
    end
    return res;
  endfunction

  // valid stays high after the handshake so back-to-back words need no gap
  task automatic send_word(opcode_t op, logic [IDX_W-1:0] idx, rgb_t c,
                           logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {v, u, c.blue, c.green, c.red, idx};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (op == OP_WRITE) begin
      texels[idx] = c;
    end else begin
      expected_rgb.push_back(predict_sample(u, v));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (r)
      REG_WIDTH:  tex_w = (value == 0) ? 1 : (value > 256) ? 256 : value;
      REG_HEIGHT: tex_h = (value == 0) ? 1 : (value > 256) ? 256 : value;
      default:    grey_mode = value[0];
    endcase
  endtask

  function automatic rgb_t random_rgb();
    rgb_t c;
    c = 48'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: c = '0;
      1: c = '1;
      default: ;
    endcase
    return c;
  endfunction

  // fill the whole in-use texture so no sample reads an unwritten texel
  task automatic fill_texture();
    for (int i = 0; i < tex_w * tex_h; i++)
      send_word(OP_WRITE, i[IDX_W-1:0], random_rgb(), COORD_W'($urandom),
                COORD_W'($urandom));
  endtask

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return COORD_W'($urandom_range(0, 65535));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [COORD_W-1:0] edges [8];
    edges = '{24'h000000, 24'h00ffff, 24'h010000, 24'h7fffff,
              24'h800000, 24'hffffff, 24'h008000, 24'hff0001};
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_SINGLE, 0);
    fill_texture();
    for (int i = 0; i < 8; i++)
      send_word(OP_SAMPLE, IDX_W'($urandom), random_rgb(), edges[i], edges[7 - i]);
    // write far beyond the texture area, then resample
    send_word(OP_WRITE, 16'hffff, '1, '0, '0);
    send_word(OP_SAMPLE, '0, '0, 24'hffffff, 24'h000000);
  endtask

  task automatic test_random_phase(int w, int h, bit grey, int n);
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_SINGLE, int'(grey));
    fill_texture();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_word(OP_WRITE, IDX_W'($urandom_range(0, tex_w * tex_h - 1)), random_rgb(),
                  COORD_W'($urandom), COORD_W'($urandom));
      else
        send_word(OP_SAMPLE, IDX_W'($urandom), random_rgb(), random_coord(),
                  random_coord());
      // hold off once until the pipe is empty
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = REG_WIDTH; cfg_data = '0;
    rx_enable = 1'b0;
    errors = 0; samples_checked = 0; items_sent = 0;
    tex_w = 256; tex_h = 256; grey_mode = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    rx_enable = 1'b1;
    test_directed();
    test_random_phase(1, 1, 0, 40);
    test_random_phase(5, 7, 1, 50);
    test_random_phase(16, 2, 0, 60);
    test_random_phase(0, 511, 0, 50);
    wait_drained();
    $display("sent %0d words, checked %0d filtered samples over 5 texture setups",
             items_sent, samples_checked);
    if (errors == 0)
      $display("[bilinear_texture_sampler] OK");
    else
      $display("[bilinear_texture_sampler] ERROR");
    $finish;
  end

endmodule
